>>> rtl/rpdg_pkg.sv
package rpdg_pkg;

   // Sizing of the datapath
   localparam int PHASE_BITS    = 32;
   localparam int AMP_BITS      = 16;
   localparam int CORDIC_STAGES = 16;

   localparam int INDEX_W    = 16;
   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int NUM_W      = INDEX_W + PHASE_BITS;
   localparam int DIV_STAGES = NUM_W;
   localparam int TURN_W     = 32;
   localparam int RES_W      = TURN_W;
   localparam int XY_W       = 34;
   localparam int TABLE_LEN  = 24;
   localparam int STAGE_IDX_W = $clog2(TABLE_LEN);

   // Pipeline depth from an accepted index to its result strobe
   localparam int PIPE_LATENCY = DIV_STAGES + CORDIC_STAGES + 3;

   // CORDIC start gain K in Q0.30
   localparam int KQ30_W = 30;
   localparam logic [KQ30_W-1:0] KQ30 = 30'd652032874;
   localparam int GAIN_PROD_W = CFG_W + KQ30_W;
   localparam logic [GAIN_PROD_W-1:0] GAIN_ROUND = GAIN_PROD_W'(1) << 14;

   // Golden-angle step as a turn fraction, rounded from a 64-bit constant
   localparam logic [63:0] GOLD64 = 64'h61C8864680B583EA;
   localparam logic [64:0] GOLD_SUM = {1'b0, GOLD64} + (65'd1 << (63 - PHASE_BITS));
   localparam logic [PHASE_BITS-1:0] GOLD_STEP = PHASE_BITS'(GOLD_SUM >> (64 - PHASE_BITS));

   // Eighth of a turn, used to centre the quadrant split
   localparam logic [TURN_W-1:0] EIGHTH_TURN = TURN_W'(1) << (TURN_W - 3);

   // Output rounding and saturation
   localparam int OUT_SHIFT = 31 - AMP_BITS;
   localparam logic signed [XY_W-1:0] ROUND_HALF = XY_W'(1) << (OUT_SHIFT - 1);
   localparam logic signed [XY_W-1:0] AMP_HI = XY_W'((1 << (AMP_BITS - 1)) - 1);
   localparam logic signed [XY_W-1:0] AMP_LO = -AMP_HI - XY_W'(1);

   // Arctangent per stage, units of 2^-32 turn
   localparam logic [29:0] ATAN_TURN [TABLE_LEN] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
      30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
      30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81
   };

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_MODE  = 4'd0,
      CSR_FULL_CIRCLE = 4'd1,
      CSR_NUM_PROJ    = 4'd2,
      CSR_GAIN        = 4'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_EAST  = 2'd0,
      QUAD_NORTH = 2'd1,
      QUAD_WEST  = 2'd2,
      QUAD_SOUTH = 2'd3
   } quad_type;

   // Beat carried along the divider row
   typedef struct packed {
      logic [INDEX_W-1:0]    rem;
      logic [NUM_W-1:0]      num;
      logic [PHASE_BITS-1:0] quo;
      logic [PHASE_BITS-1:0] gold;
   } div_pay_type;

   // Beat carried along the rotation row
   typedef struct packed {
      quad_type                quad;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [RES_W-1:0] res;
   } cordic_pay_type;

   function automatic logic signed [RES_W-1:0] atan_step(
      input logic [STAGE_IDX_W-1:0] k
   );
      logic signed [RES_W-1:0] a;
      a = '0;
      if (int'(k) < TABLE_LEN) begin
         a = $signed(RES_W'(ATAN_TURN[k]));
      end
      return a;
   endfunction

   // Round half up, then clamp to the signed output range
   function automatic logic signed [AMP_BITS-1:0] to_amp(
      input logic signed [XY_W-1:0] v
   );
      logic signed [XY_W-1:0] t;
      logic signed [XY_W-1:0] r;
      t = v + ROUND_HALF;
      r = t >>> OUT_SHIFT;
      if (r > AMP_HI) begin
         r = AMP_HI;
      end else if (r < AMP_LO) begin
         r = AMP_LO;
      end
      return AMP_BITS'(r);
   endfunction

endpackage

>>> rtl/rpdg_div_cell.sv
module rpdg_div_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rpdg_pkg::INDEX_W-1:0]  divisor,
   input  logic                          in_valid,
   input  rpdg_pkg::div_pay_type         in_pay,
   output logic                          out_valid,
   output rpdg_pkg::div_pay_type         out_pay
);

   logic [rpdg_pkg::INDEX_W:0] trial;
   logic                       fits;
   logic                       valid_ff;
   rpdg_pkg::div_pay_type      pay_in;
   rpdg_pkg::div_pay_type      pay_ff;

   // Shift one numerator bit into the remainder, subtract where it fits
   always_comb begin
      trial = {in_pay.rem, in_pay.num[rpdg_pkg::NUM_W-1]};
      fits  = trial >= {1'b0, divisor};
      pay_in      = in_pay;
      pay_in.rem  = fits ? rpdg_pkg::INDEX_W'(trial - {1'b0, divisor})
                         : rpdg_pkg::INDEX_W'(trial);
      pay_in.num  = {in_pay.num[rpdg_pkg::NUM_W-2:0], 1'b0};
      pay_in.quo  = {in_pay.quo[rpdg_pkg::PHASE_BITS-2:0], fits};
   end

   // Advance the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      pay_ff <= pay_in;
   end

   assign out_valid = valid_ff;
   assign out_pay   = pay_ff;

endmodule

>>> rtl/rpdg_cordic_cell.sv
module rpdg_cordic_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rpdg_pkg::STAGE_IDX_W-1:0]  stage_idx,
   input  logic                              in_valid,
   input  rpdg_pkg::cordic_pay_type          in_pay,
   output logic                              out_valid,
   output rpdg_pkg::cordic_pay_type          out_pay
);

   logic signed [rpdg_pkg::XY_W-1:0]  dx;
   logic signed [rpdg_pkg::XY_W-1:0]  dy;
   logic signed [rpdg_pkg::RES_W-1:0] ang;
   logic                              valid_ff;
   rpdg_pkg::cordic_pay_type          pay_in;
   rpdg_pkg::cordic_pay_type          pay_ff;

   // One micro-rotation towards zero residual angle
   always_comb begin
      dx  = in_pay.y >>> stage_idx;
      dy  = in_pay.x >>> stage_idx;
      ang = rpdg_pkg::atan_step(stage_idx);
      pay_in = in_pay;
      if (!in_pay.res[rpdg_pkg::RES_W-1]) begin
         pay_in.x   = in_pay.x - dx;
         pay_in.y   = in_pay.y + dy;
         pay_in.res = in_pay.res - ang;
      end else begin
         pay_in.x   = in_pay.x + dx;
         pay_in.y   = in_pay.y - dy;
         pay_in.res = in_pay.res + ang;
      end
   end

   // Advance the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      pay_ff <= pay_in;
   end

   assign out_valid = valid_ff;
   assign out_pay   = pay_ff;

endmodule

>>> rtl/radial_projection_direction_gen_unit.sv
// Channel   Handshake              Beat
// -------   ---------------------  ------------------------------------------
// request   start / busy           req_proj_index
// response  rsp_valid (strobe)     rsp_read_amp, rsp_phase_amp
// csr       csr_valid / csr_ready  csr_index, csr_wdata
//
// One index is taken every cycle; busy is high only while reset is applied.
// Each result passes in order through the entry stage, the 48-cell restoring
// divider row, the set-up stage, the 16-cell CORDIC row and the output stage.
// Synchronous reset clears all beat valids and restores the register defaults.
// The response side has no back-pressure: every strobe is a delivered beat.
module radial_projection_direction_gen_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [rpdg_pkg::INDEX_W-1:0]          req_proj_index,
   output logic                                  rsp_valid,
   output logic signed [rpdg_pkg::AMP_BITS-1:0]  rsp_read_amp,
   output logic signed [rpdg_pkg::AMP_BITS-1:0]  rsp_phase_amp,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rpdg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rpdg_pkg::CFG_W-1:0]            csr_wdata
);

   // Configuration registers
   logic                          angle_mode_ff;
   logic                          full_circle_ff;
   logic [rpdg_pkg::INDEX_W-1:0]  num_proj_ff;
   logic [rpdg_pkg::CFG_W-1:0]    gain_ff;

   // Entry stage
   logic [rpdg_pkg::INDEX_W-1:0]    divisor;
   logic [rpdg_pkg::NUM_W-1:0]      num_full;
   logic [rpdg_pkg::NUM_W-1:0]      num_half;
   logic [rpdg_pkg::PHASE_BITS-1:0] gold_prod;
   logic                            entry_valid_ff;
   rpdg_pkg::div_pay_type           entry_pay_in;
   rpdg_pkg::div_pay_type           entry_pay_ff;

   // Divider row
   logic                  div_valid [0:rpdg_pkg::DIV_STAGES];
   rpdg_pkg::div_pay_type div_pay   [0:rpdg_pkg::DIV_STAGES];

   // Rotation set-up stage
   logic [rpdg_pkg::PHASE_BITS-1:0]  phase;
   logic [rpdg_pkg::TURN_W-1:0]      turn;
   logic [rpdg_pkg::TURN_W-1:0]      turn_sum;
   logic [rpdg_pkg::TURN_W-1:0]      resid;
   logic [rpdg_pkg::GAIN_PROD_W-1:0] gain_prod;
   logic                             prep_valid_ff;
   rpdg_pkg::cordic_pay_type         prep_pay_in;
   rpdg_pkg::cordic_pay_type         prep_pay_ff;

   // Rotation row
   logic                     cor_valid [0:rpdg_pkg::CORDIC_STAGES];
   rpdg_pkg::cordic_pay_type cor_pay   [0:rpdg_pkg::CORDIC_STAGES];

   // Output stage
   rpdg_pkg::cordic_pay_type                last_pay;
   logic signed [rpdg_pkg::XY_W-1:0]        cos_v;
   logic signed [rpdg_pkg::XY_W-1:0]        sin_v;
   logic                                    rsp_valid_ff;
   logic signed [rpdg_pkg::AMP_BITS-1:0]    read_amp_ff;
   logic signed [rpdg_pkg::AMP_BITS-1:0]    phase_amp_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   // Register writes; unknown indices are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_mode_ff  <= 1'b0;
         full_circle_ff <= 1'b1;
         num_proj_ff    <= rpdg_pkg::INDEX_W'(256);
         gain_ff        <= rpdg_pkg::CFG_W'(32768);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rpdg_pkg::CSR_ANGLE_MODE:  angle_mode_ff  <= csr_wdata[0];
            rpdg_pkg::CSR_FULL_CIRCLE: full_circle_ff <= csr_wdata[0];
            rpdg_pkg::CSR_NUM_PROJ:    num_proj_ff    <= csr_wdata;
            rpdg_pkg::CSR_GAIN:        gain_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Form the dividend for uniform spacing and the golden-angle phase
   always_comb begin
      divisor   = (num_proj_ff == '0) ? rpdg_pkg::INDEX_W'(1) : num_proj_ff;
      num_full  = {req_proj_index, rpdg_pkg::PHASE_BITS'(0)};
      num_half  = {1'b0, req_proj_index, (rpdg_pkg::PHASE_BITS-1)'(0)};
      gold_prod = rpdg_pkg::PHASE_BITS'(req_proj_index) * rpdg_pkg::GOLD_STEP;
      entry_pay_in.rem  = '0;
      entry_pay_in.quo  = '0;
      entry_pay_in.num  = (full_circle_ff ? num_full : num_half)
                          + rpdg_pkg::NUM_W'(divisor >> 1);
      entry_pay_in.gold = full_circle_ff ? gold_prod
                          : {gold_prod[rpdg_pkg::PHASE_BITS-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      entry_pay_ff <= entry_pay_in;
   end

   assign div_valid[0] = entry_valid_ff;
   assign div_pay[0]   = entry_pay_ff;

   // Restoring divider, one quotient bit per cell
   for (genvar i = 0; i < rpdg_pkg::DIV_STAGES; i++) begin : g_div
      rpdg_div_cell u_div_cell (
         .clock     (clock),
         .reset     (reset),
         .divisor   (divisor),
         .in_valid  (div_valid[i]),
         .in_pay    (div_pay[i]),
         .out_valid (div_valid[i+1]),
         .out_pay   (div_pay[i+1])
      );
   end

   // Pick the phase, split off the quadrant and load the start vector
   always_comb begin
      phase = angle_mode_ff ? div_pay[rpdg_pkg::DIV_STAGES].gold
                            : div_pay[rpdg_pkg::DIV_STAGES].quo;
      turn  = rpdg_pkg::TURN_W'({phase, rpdg_pkg::TURN_W'(0)} >> rpdg_pkg::PHASE_BITS);
      turn_sum = turn + rpdg_pkg::EIGHTH_TURN;
      prep_pay_in.quad = rpdg_pkg::quad_type'(turn_sum[rpdg_pkg::TURN_W-1 -: 2]);
      resid = turn - {turn_sum[rpdg_pkg::TURN_W-1 -: 2], (rpdg_pkg::TURN_W-2)'(0)};
      prep_pay_in.res = $signed(resid);
      gain_prod = rpdg_pkg::GAIN_PROD_W'(gain_ff) * rpdg_pkg::GAIN_PROD_W'(rpdg_pkg::KQ30)
                  + rpdg_pkg::GAIN_ROUND;
      prep_pay_in.x = $signed(rpdg_pkg::XY_W'(gain_prod >> 15));
      prep_pay_in.y = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= div_valid[rpdg_pkg::DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      prep_pay_ff <= prep_pay_in;
   end

   assign cor_valid[0] = prep_valid_ff;
   assign cor_pay[0]   = prep_pay_ff;

   // Rotation row, one micro-rotation per cell
   for (genvar k = 0; k < rpdg_pkg::CORDIC_STAGES; k++) begin : g_cordic
      rpdg_cordic_cell u_cordic_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (rpdg_pkg::STAGE_IDX_W'(k)),
         .in_valid  (cor_valid[k]),
         .in_pay    (cor_pay[k]),
         .out_valid (cor_valid[k+1]),
         .out_pay   (cor_pay[k+1])
      );
   end

   // Fold the quadrant back in
   always_comb begin
      last_pay = cor_pay[rpdg_pkg::CORDIC_STAGES];
      case (last_pay.quad)
         rpdg_pkg::QUAD_EAST: begin
            cos_v = last_pay.x;
            sin_v = last_pay.y;
         end
         rpdg_pkg::QUAD_NORTH: begin
            cos_v = -last_pay.y;
            sin_v = last_pay.x;
         end
         rpdg_pkg::QUAD_WEST: begin
            cos_v = -last_pay.x;
            sin_v = -last_pay.y;
         end
         default: begin
            cos_v = last_pay.y;
            sin_v = -last_pay.x;
         end
      endcase
   end

   // Round, saturate and hold the response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cor_valid[rpdg_pkg::CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (cor_valid[rpdg_pkg::CORDIC_STAGES]) begin
         read_amp_ff  <= rpdg_pkg::to_amp(cos_v);
         phase_amp_ff <= rpdg_pkg::to_amp(sin_v);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_amp  = read_amp_ff;
   assign rsp_phase_amp = phase_amp_ff;

endmodule

>>> rtl/rpdg_checker.sv
module rpdg_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // No response beat straight after a reset edge
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

   // Every accepted index yields its beat after the fixed latency
   a_beat_delivered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(rpdg_pkg::PIPE_LATENCY) rsp_valid)
      else $error("accepted index produced no response beat");

   // No beat without a matching accepted index
   a_no_spurious_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, rpdg_pkg::PIPE_LATENCY))
      else $error("response beat without an accepted index");

endmodule

bind radial_projection_direction_gen_unit rpdg_checker u_rpdg_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

>>> sim/radial_projection_direction_gen_checker.sv
module radial_projection_direction_gen_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic [rpdg_pkg::INDEX_W-1:0]          req_proj_index,
   input  logic                                  rsp_valid,
   input  logic signed [rpdg_pkg::AMP_BITS-1:0]  rsp_read_amp,
   input  logic signed [rpdg_pkg::AMP_BITS-1:0]  rsp_phase_amp,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [rpdg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rpdg_pkg::CFG_W-1:0]            csr_wdata,
   output int                                    fail_count,
   output int                                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     ROTATIONS    = 16;
   localparam int     REPORT_LIMIT = 10;
   localparam longint START_GAIN_K = 64'sd652032874;   // 0.6072529350 in Q2.30
   localparam longint GAIN_HALF    = 64'sd16384;
   localparam longint AMP_MAX      = 64'sd32767;
   localparam longint AMP_MIN      = -64'sd32768;
   localparam logic [31:0] QUARTER_CENTRE = 32'h2000_0000;

   // Golden-angle step as a 32-bit turn fraction, rounded from a 64-bit constant
   localparam logic [63:0] GOLD_TURN64 = 64'h61C8_8646_80B5_83EA;
   localparam logic [63:0] GOLDEN_STEP = (GOLD_TURN64 + 64'h8000_0000) >> 32;

   typedef struct packed {
      logic signed [rpdg_pkg::AMP_BITS-1:0] read_amp;
      logic signed [rpdg_pkg::AMP_BITS-1:0] phase_amp;
   } direction_type;

   // Arctangent of 2^-k in units of 2^-32 turn
   longint atan_turns [ROTATIONS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838,  5340245,   2670163,   1335087,  667544,   333772,
      166886,    83443,     41722,     20861
   };

   logic                        cfg_golden;
   logic                        cfg_full;
   logic [rpdg_pkg::CFG_W-1:0]  cfg_num_proj;
   logic [rpdg_pkg::CFG_W-1:0]  cfg_gain;
   direction_type               expected_dirs [$];
   direction_type               head;
   int                          mismatch_total = 0;

   assign fail_count    = mismatch_total;
   assign pending_count = expected_dirs.size();

   // Round half up to Q1.15 and clamp
   function automatic logic signed [rpdg_pkg::AMP_BITS-1:0] to_q15(input longint v);
      longint r;
      r = (v + GAIN_HALF) >>> 15;
      if (r > AMP_MAX) begin
         r = AMP_MAX;
      end else if (r < AMP_MIN) begin
         r = AMP_MIN;
      end
      return rpdg_pkg::AMP_BITS'(r);
   endfunction

   // Direction of one projection under the current register copy
   function automatic direction_type predict_direction(
      input logic [rpdg_pkg::INDEX_W-1:0] idx
   );
      logic [63:0]   divisor;
      logic [63:0]   numer;
      logic [63:0]   turn;
      logic [31:0]   z;
      logic [31:0]   rz;
      logic [1:0]    q;
      longint        res;
      longint        x;
      longint        y;
      longint        dx;
      longint        dy;
      longint        c;
      longint        s;
      direction_type d;
      if (!cfg_golden) begin
         divisor = (cfg_num_proj == '0) ? 64'd1 : 64'(cfg_num_proj);
         numer   = cfg_full ? (64'(idx) << 32) : (64'(idx) << 31);
         turn    = (numer + divisor / 2) / divisor;
      end else begin
         turn = 64'(idx) * GOLDEN_STEP;
         if (!cfg_full) begin
            turn = turn << 1;
         end
      end
      z   = turn[31:0];
      q   = 2'((z + QUARTER_CENTRE) >> 30);
      rz  = z - {q, 30'd0};
      res = longint'($signed(rz));
      x   = (longint'(cfg_gain) * START_GAIN_K + GAIN_HALF) >>> 15;
      y   = 0;
      // rotate the residual towards zero
      for (int k = 0; k < ROTATIONS; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (res >= 0) begin
            x   = x - dx;
            y   = y + dy;
            res = res - atan_turns[k];
         end else begin
            x   = x + dx;
            y   = y - dy;
            res = res + atan_turns[k];
         end
      end
      // map back to the selected quarter turn
      case (rpdg_pkg::quad_type'(q))
         rpdg_pkg::QUAD_EAST: begin
            c = x;
            s = y;
         end
         rpdg_pkg::QUAD_NORTH: begin
            c = -y;
            s = x;
         end
         rpdg_pkg::QUAD_WEST: begin
            c = -x;
            s = -y;
         end
         default: begin
            c = y;
            s = -x;
         end
      endcase
      d.read_amp  = to_q15(c);
      d.phase_amp = to_q15(s);
      return d;
   endfunction

   // Track register writes, queue predictions, compare response beats
   always @(posedge clock) begin
      if (reset) begin
         cfg_golden   <= 1'b0;
         cfg_full     <= 1'b1;
         cfg_num_proj <= 16'd256;
         cfg_gain     <= 16'd32768;
         expected_dirs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rpdg_pkg::CSR_ANGLE_MODE:  cfg_golden   <= csr_wdata[0];
               rpdg_pkg::CSR_FULL_CIRCLE: cfg_full     <= csr_wdata[0];
               rpdg_pkg::CSR_NUM_PROJ:    cfg_num_proj <= csr_wdata;
               rpdg_pkg::CSR_GAIN:        cfg_gain     <= csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            expected_dirs.push_back(predict_direction(req_proj_index));
         end
         if (rsp_valid) begin
            if (expected_dirs.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= REPORT_LIMIT) begin
                  $display("unexpected response beat: read %0d phase %0d",
                           rsp_read_amp, rsp_phase_amp);
               end
            end else begin
               head = expected_dirs.pop_front();
               if (head.read_amp !== rsp_read_amp || head.phase_amp !== rsp_phase_amp) begin
                  mismatch_total++;
                  if (mismatch_total <= REPORT_LIMIT) begin
                     $display("direction mismatch: read exp %0d got %0d, phase exp %0d got %0d",
                              head.read_amp, rsp_read_amp, head.phase_amp, rsp_phase_amp);
                  end
               end
            end
         end
      end
   end

endmodule

>>> sim/radial_projection_direction_gen_unit_tb.sv
module radial_projection_direction_gen_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int TAIL_CYCLES      = 80;
   localparam int BLOCKS_PER_PHASE = 5;
   localparam int ITEMS_PER_BLOCK  = 48;
   localparam logic [rpdg_pkg::CSR_IDX_W-1:0] CSR_FIRST_UNMAPPED = 4'd4;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  start;
   logic                                  busy;
   logic [rpdg_pkg::INDEX_W-1:0]          req_proj_index;
   logic                                  rsp_valid;
   logic signed [rpdg_pkg::AMP_BITS-1:0]  rsp_read_amp;
   logic signed [rpdg_pkg::AMP_BITS-1:0]  rsp_phase_amp;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [rpdg_pkg::CSR_IDX_W-1:0]        csr_index;
   logic [rpdg_pkg::CFG_W-1:0]            csr_wdata;
   int                                    fail_count;
   int                                    pending_count;
   int                                    cycle_count = 0;
   int                                    sender_idle_pct = 0;

   always #1 clock = ~clock;

   radial_projection_direction_gen_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_proj_index (req_proj_index),
      .rsp_valid      (rsp_valid),
      .rsp_read_amp   (rsp_read_amp),
      .rsp_phase_amp  (rsp_phase_amp),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   radial_projection_direction_gen_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_proj_index (req_proj_index),
      .rsp_valid      (rsp_valid),
      .rsp_read_amp   (rsp_read_amp),
      .rsp_phase_amp  (rsp_phase_amp),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   // Drop the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Send one index beat, idling at random first; start stays high afterwards
   task automatic issue_index(input logic [rpdg_pkg::INDEX_W-1:0] idx);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_proj_index <= idx;
      do @(posedge clock); while (busy);
   endtask

   // Hold off the sender until every expected result has come
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // One register write beat
   task automatic write_csr(input logic [rpdg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rpdg_pkg::CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Bring the block to idle and load a full setting; junk in unused bits of 1-bit fields
   task automatic apply_setting(input logic golden, input logic full,
                                input logic [rpdg_pkg::CFG_W-1:0] nproj,
                                input logic [rpdg_pkg::CFG_W-1:0] g);
      drain_results();
      write_csr(rpdg_pkg::CSR_ANGLE_MODE, (16'($urandom) & 16'hFFFE) | 16'(golden));
      write_csr(rpdg_pkg::CSR_FULL_CIRCLE, (16'($urandom) & 16'hFFFE) | 16'(full));
      write_csr(rpdg_pkg::CSR_NUM_PROJ, nproj);
      write_csr(rpdg_pkg::CSR_GAIN, g);
   endtask

   // Random settings with extremes, then runs of consecutive indices mixed with loose ones
   task automatic run_random_phase(input int idle_pct);
      logic [rpdg_pkg::CFG_W-1:0]   nproj;
      logic [rpdg_pkg::CFG_W-1:0]   g;
      logic [rpdg_pkg::INDEX_W-1:0] base;
      int                           sent;
      int                           len;
      sender_idle_pct = idle_pct;
      for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
         case ($urandom_range(5))
            0:       nproj = 16'd0;
            1:       nproj = 16'd1;
            2:       nproj = 16'hFFFF;
            3:       nproj = 16'($urandom_range(2, 16));
            4:       nproj = 16'($urandom_range(17, 1024));
            default: nproj = 16'($urandom);
         endcase
         case ($urandom_range(5))
            0:       g = 16'd0;
            1:       g = 16'd32768;
            2:       g = 16'hFFFF;
            3:       g = 16'd32767;
            4:       g = 16'($urandom_range(32768));
            default: g = 16'($urandom);
         endcase
         apply_setting(1'($urandom), 1'($urandom), nproj, g);
         if ($urandom_range(2) == 0) begin
            write_csr(CSR_FIRST_UNMAPPED + 4'($urandom_range(11)), 16'($urandom));
         end
         sent = 0;
         while (sent < ITEMS_PER_BLOCK) begin
            if ($urandom_range(99) < 60) begin
               base = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(511));
               len  = $urandom_range(4, 16);
               for (int j = 0; j < len; j++) begin
                  issue_index(base + 16'(j));
               end
               sent += len;
            end else begin
               issue_index(16'($urandom));
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_proj_index <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: cardinal directions, full scale at quarter turns, wrap past the count
      issue_index(16'd0);
      issue_index(16'd64);
      issue_index(16'd128);
      issue_index(16'd192);
      issue_index(16'd32);
      issue_index(16'd255);
      issue_index(16'd256);
      issue_index(16'hFFFF);

      // Golden angle, full and half turn
      apply_setting(1'b1, 1'b1, 16'd256, 16'd32768);
      issue_index(16'd0);
      issue_index(16'd1);
      issue_index(16'hFFFF);
      apply_setting(1'b1, 1'b0, 16'd256, 16'd32768);
      issue_index(16'd1);
      issue_index(16'h8000);
      issue_index(16'hFFFF);

      // Zero projection count acts as one
      apply_setting(1'b0, 1'b0, 16'd0, 16'd32768);
      issue_index(16'd0);
      issue_index(16'd1);

      // Gain above unity saturates
      apply_setting(1'b0, 1'b1, 16'd1, 16'hFFFF);
      issue_index(16'd0);
      issue_index(16'd1);

      // Largest count, zero gain
      apply_setting(1'b0, 1'b1, 16'hFFFF, 16'd0);
      issue_index(16'hFFFF);
      issue_index(16'h7FFF);

      // Write to an unmapped register must change nothing
      apply_setting(1'b0, 1'b1, 16'd4, 16'd32767);
      write_csr(CSR_FIRST_UNMAPPED, 16'hFFFF);
      issue_index(16'd1);
      issue_index(16'd2);
      issue_index(16'd3);

      run_random_phase(33);
      run_random_phase(49);
      run_random_phase(0);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/rpdg_pkg.sv
rtl/rpdg_div_cell.sv
rtl/rpdg_cordic_cell.sv
rtl/radial_projection_direction_gen_unit.sv
rtl/rpdg_checker.sv
sim/radial_projection_direction_gen_checker.sv
sim/radial_projection_direction_gen_unit_tb.sv
